// File: rtl/psl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psl_pkg - shared types, codes and pattern table
// Item layouts, action codes and the twelve-entry LED pattern table of the
// priority status LED blinker.
// ----------------------------------------------------------------------------
package psl_pkg;

  // Slot index width and tick counter width
  localparam int SLOT_W    = 4;
  localparam int TICK_W    = 5;
  localparam int TABLE_LEN = 12;

  // Action codes
  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_RAISE     = 2'd1;
  localparam logic [1:0] ACT_DROP      = 2'd2;
  localparam logic [1:0] ACT_POWER_OFF = 2'd3;

  // Pattern kinds
  localparam logic [1:0] KIND_SOLID_GREEN = 2'd0;
  localparam logic [1:0] KIND_SOLID_RED   = 2'd1;
  localparam logic [1:0] KIND_BLINK_GREEN = 2'd2;
  localparam logic [1:0] KIND_BLINK_RED   = 2'd3;

  // Phase lengths in ms, and in 100 ms ticks
  localparam int TICK_MS = 100;
  localparam int MS_500  = 500;
  localparam int MS_800  = 800;
  localparam int MS_1500 = 1500;
  localparam int MS_3000 = 3000;
  localparam logic [TICK_W-1:0] T_NONE = '0;
  localparam logic [TICK_W-1:0] T_500  = TICK_W'(MS_500 / TICK_MS);
  localparam logic [TICK_W-1:0] T_800  = TICK_W'(MS_800 / TICK_MS);
  localparam logic [TICK_W-1:0] T_1500 = TICK_W'(MS_1500 / TICK_MS);
  localparam logic [TICK_W-1:0] T_3000 = TICK_W'(MS_3000 / TICK_MS);

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] status_slot;
    logic              test_hold;
  } in_item_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
  } out_item_t;

  // Pattern kind of a slot
  function automatic logic [1:0] pat_kind(input logic [SLOT_W-1:0] slot);
    logic [1:0] k;
    case (slot) inside
      4'd1, 4'd3, 4'd4, 4'd10: k = KIND_BLINK_RED;
      4'd2, 4'd6, 4'd7, 4'd11: k = KIND_BLINK_GREEN;
      4'd9:                    k = KIND_SOLID_RED;
      default:                 k = KIND_SOLID_GREEN;
    endcase
    return k;
  endfunction

  // Dark phase length (table open time)
  function automatic logic [TICK_W-1:0] pat_open_ticks(input logic [SLOT_W-1:0] slot);
    logic [TICK_W-1:0] t;
    case (slot) inside
      4'd1, 4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11: t = T_500;
      4'd4:                                       t = T_1500;
      default:                                    t = T_NONE;
    endcase
    return t;
  endfunction

  // Lit phase length (table close time)
  function automatic logic [TICK_W-1:0] pat_close_ticks(input logic [SLOT_W-1:0] slot);
    logic [TICK_W-1:0] t;
    case (slot) inside
      4'd1, 4'd2, 4'd6, 4'd7, 4'd10: t = T_500;
      4'd3:                          t = T_800;
      4'd4:                          t = T_1500;
      4'd11:                         t = T_3000;
      default:                       t = T_NONE;
    endcase
    return t;
  endfunction

  function automatic logic pat_is_solid(input logic [SLOT_W-1:0] slot);
    return (pat_open_ticks(slot) == T_NONE) || (pat_close_ticks(slot) == T_NONE);
  endfunction

endpackage
`default_nettype wire

// File: rtl/psl_winner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psl_winner - status slot priority encoder
// Returns the lowest-numbered active slot from 1 up to one below the table size.
// ----------------------------------------------------------------------------
module psl_winner #(
  parameter int SLOT_COUNT = 12
) (
  input  wire logic [SLOT_COUNT-1:0]     mask,
  output logic                           found,
  output logic [psl_pkg::SLOT_W-1:0]     idx
);
  import psl_pkg::*;

  localparam int SLOT_LIM = (SLOT_COUNT < TABLE_LEN) ? SLOT_COUNT : TABLE_LEN;

  // scan from the top down so the lowest set slot is last to write
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOT_LIM - 1; i >= 1; i--) begin
      if (mask[i]) begin
        found = 1'b1;
        idx   = SLOT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/priority_status_led_blinker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item waits in the input register, then its LED levels are
//   written to the result register; one item per cycle sustained while the
//   result side does not stall, set by the single pass through the slot
//   priority encoder and phase counter update.
// A stalled result holds the item in the input register, which then stalls the input.
// Reset (rst_n low, synchronous): no slots active, LEDs off, counters clear,
//   both stages empty.
// ----------------------------------------------------------------------------
// priority_status_led_blinker_core - two-LED priority status blinker
// Keeps active status slots, picks the highest priority one and steps its
// solid or blinking pattern on each 100 ms tick item; power-off forces red.
// ----------------------------------------------------------------------------
module priority_status_led_blinker_core #(
  parameter int SLOT_COUNT   = 12,
  parameter int FOREVER_MARK = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire psl_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psl_pkg::out_item_t      out_item
);
  import psl_pkg::*;

  localparam int SLOT_LIM = (SLOT_COUNT < TABLE_LEN) ? SLOT_COUNT : TABLE_LEN;
  localparam logic [SLOT_W:0] SLOT_LIM_V = (SLOT_W + 1)'(SLOT_LIM);
  localparam logic [7:0]      FOREVER_V  = 8'(FOREVER_MARK);

  // pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  // block state
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [7:0]            repeats_r, repeats_nxt;
  logic                  fresh_r, fresh_nxt;
  logic                  toggle_r, toggle_nxt;
  logic                  lit_phase_r, lit_phase_nxt;
  logic [TICK_W-1:0]     lit_ticks_r, lit_ticks_nxt;
  logic [TICK_W-1:0]     dark_ticks_r, dark_ticks_nxt;
  logic                  red_r, red_nxt;
  logic                  green_r, green_nxt;
  logic                  powered_down_r, powered_down_nxt;

  logic                  advance;
  logic                  proc;
  logic                  slot_ok;
  logic [SLOT_COUNT-1:0] slot_bit;
  logic [SLOT_COUNT-1:0] win_mask;
  logic                  win_found;
  logic [SLOT_W-1:0]     win_idx;
  logic [SLOT_W-1:0]     load_slot;
  logic [1:0]            win_kind;
  logic                  app_red, app_green, app_toggle;
  logic                  ph_lit;
  logic [TICK_W-1:0]     lit_cnt, dark_cnt, lit_inc, dark_inc;

  // handshake: stage 1 moves on when the result register is free or emptying
  assign advance   = !out_valid_r || !out_stall;
  assign proc      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // slot decode
  assign slot_ok  = (in_item_r.status_slot != '0) &&
                    ({1'b0, in_item_r.status_slot} < SLOT_LIM_V);
  assign slot_bit = {{(SLOT_COUNT - 1){1'b0}}, 1'b1} << in_item_r.status_slot;
  assign win_mask = (in_item_r.action == ACT_DROP) ? (active_r & ~slot_bit) : active_r;

  psl_winner #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_winner (
    .mask  (win_mask),
    .found (win_found),
    .idx   (win_idx)
  );

  assign load_slot = (in_item_r.action == ACT_RAISE) ? in_item_r.status_slot : win_idx;
  assign win_kind  = pat_kind(win_idx);

  // pattern application at a phase end
  always_comb begin
    app_toggle = toggle_r;
    case (win_kind)
      KIND_SOLID_GREEN: begin
        app_red = 1'b0; app_green = 1'b1;
      end
      KIND_SOLID_RED: begin
        app_red = 1'b1; app_green = 1'b0;
      end
      KIND_BLINK_GREEN: begin
        app_toggle = !toggle_r; app_red = 1'b0; app_green = !toggle_r;
      end
      default: begin
        app_toggle = !toggle_r; app_red = !toggle_r; app_green = 1'b0;
      end
    endcase
  end

  // phase counters, restarted by a fresh pattern
  assign ph_lit   = fresh_r ? 1'b1 : lit_phase_r;
  assign lit_cnt  = fresh_r ? '0 : lit_ticks_r;
  assign dark_cnt = fresh_r ? '0 : dark_ticks_r;
  assign lit_inc  = lit_cnt + TICK_W'(1);
  assign dark_inc = dark_cnt + TICK_W'(1);

  // next state for the item in stage 1
  always_comb begin
    active_nxt       = active_r;
    repeats_nxt      = repeats_r;
    fresh_nxt        = fresh_r;
    toggle_nxt       = toggle_r;
    lit_phase_nxt    = lit_phase_r;
    lit_ticks_nxt    = lit_ticks_r;
    dark_ticks_nxt   = dark_ticks_r;
    red_nxt          = red_r;
    green_nxt        = green_r;
    powered_down_nxt = powered_down_r;
    if (!in_item_r.test_hold) begin
      case (in_item_r.action)
        ACT_TICK: begin
          if (!powered_down_r && (repeats_r != 8'd0) && win_found) begin
            fresh_nxt      = 1'b0;
            lit_phase_nxt  = ph_lit;
            lit_ticks_nxt  = lit_cnt;
            dark_ticks_nxt = dark_cnt;
            if (pat_is_solid(win_idx)) begin
              repeats_nxt = repeats_r - 8'd1;
              red_nxt     = app_red;
              green_nxt   = app_green;
              toggle_nxt  = app_toggle;
            end else if (ph_lit) begin
              if (pat_close_ticks(win_idx) <= lit_inc) begin
                lit_phase_nxt = 1'b0;
                if (repeats_r < FOREVER_V) begin
                  repeats_nxt = repeats_r - 8'd1;
                end
                lit_ticks_nxt = '0;
                red_nxt       = app_red;
                green_nxt     = app_green;
                toggle_nxt    = app_toggle;
              end else begin
                lit_ticks_nxt = lit_inc;
              end
            end else begin
              if (pat_open_ticks(win_idx) <= dark_inc) begin
                lit_phase_nxt  = 1'b1;
                dark_ticks_nxt = '0;
                red_nxt        = app_red;
                green_nxt      = app_green;
                toggle_nxt     = app_toggle;
              end else begin
                dark_ticks_nxt = dark_inc;
              end
            end
          end
        end
        ACT_RAISE, ACT_DROP: begin
          if (slot_ok) begin
            active_nxt = (in_item_r.action == ACT_RAISE) ? (active_r | slot_bit)
                                                         : (active_r & ~slot_bit);
            if ((in_item_r.action == ACT_RAISE) || win_found) begin
              red_nxt     = 1'b0;
              green_nxt   = 1'b0;
              repeats_nxt = pat_is_solid(load_slot) ? 8'd1 : FOREVER_V;
              fresh_nxt   = 1'b1;
              toggle_nxt  = 1'b0;
            end
          end
        end
        default: begin
          powered_down_nxt = 1'b1;
          red_nxt          = 1'b1;
          green_nxt        = 1'b0;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      active_r       <= '0;
      repeats_r      <= '0;
      fresh_r        <= 1'b0;
      toggle_r       <= 1'b0;
      lit_phase_r    <= 1'b0;
      lit_ticks_r    <= '0;
      dark_ticks_r   <= '0;
      red_r          <= 1'b0;
      green_r        <= 1'b0;
      powered_down_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (proc) begin
        active_r       <= active_nxt;
        repeats_r      <= repeats_nxt;
        fresh_r        <= fresh_nxt;
        toggle_r       <= toggle_nxt;
        lit_phase_r    <= lit_phase_nxt;
        lit_ticks_r    <= lit_ticks_nxt;
        dark_ticks_r   <= dark_ticks_nxt;
        red_r          <= red_nxt;
        green_r        <= green_nxt;
        powered_down_r <= powered_down_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_item_r.red_on   <= red_nxt;
      out_item_r.green_on <= green_nxt;
    end
  end

  // checks
  a_slot0_never_active: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r[0])
    else $error("slot 0 became active");

  a_power_off_red: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !in_item_r.test_hold && (in_item_r.action == ACT_POWER_OFF)
    |=> powered_down_r && out_item_r.red_on && !out_item_r.green_on)
    else $error("power off did not force red");

  a_hold_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.test_hold |=> $stable(red_r) && $stable(green_r) &&
    $stable(active_r))
    else $error("held item changed state");

  a_result_matches_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.red_on == red_r) && (out_item_r.green_on == green_r))
    else $error("result register out of step with LED levels");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the priority status LED blinker core
// Sends tick, raise, drop, power-off and held items through the valid/stall
// input channel, predicts the red and green LED levels after every item and
// compares each result against the oldest predicted pair. Both channels idle
// and stall in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import psl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_GOAL = 760;

  // Predicts LED levels per item and checks results in arrival order
  class led_level_scoreboard;
    localparam bit [7:0] ENDLESS = 8'd255;

    bit [11:0]      active_mask;
    bit [7:0]       repeats_left;
    bit             fresh;
    bit             blink_level;
    bit             in_lit;
    bit [4:0]       lit_count;
    bit [4:0]       dark_count;
    bit             red;
    bit             green;
    bit             powered_off;
    bit [1:0]       kind_of [12];
    int unsigned    open_ticks [12];
    int unsigned    close_ticks [12];
    out_item_t      levels_due [$];
    int unsigned    mismatches;
    int unsigned    matched;

    function new();
      kind_of = '{KIND_SOLID_GREEN, KIND_BLINK_RED, KIND_BLINK_GREEN, KIND_BLINK_RED,
                  KIND_BLINK_RED, KIND_SOLID_GREEN, KIND_BLINK_GREEN, KIND_BLINK_GREEN,
                  KIND_SOLID_GREEN, KIND_SOLID_RED, KIND_BLINK_RED, KIND_BLINK_GREEN};
      // dark phase uses open time, lit phase uses close time, in 100 ms ticks
      open_ticks  = '{0, 5, 5, 5, 15, 0, 5, 5, 0, 0, 5, 5};
      close_ticks = '{0, 5, 5, 8, 15, 0, 5, 5, 0, 0, 5, 30};
    endfunction

    function bit slot_valid(int unsigned s);
      return s >= 1 && s < 12;
    endfunction

    function bit solid(int unsigned s);
      return open_ticks[s] == 0 || close_ticks[s] == 0;
    endfunction

    // highest priority active slot, 0 when none
    function int unsigned top_slot();
      for (int unsigned s = 1; s < 12; s++)
        if (active_mask[s]) return s;
      return 0;
    endfunction

    function void load(int unsigned s);
      red          = 1'b0;
      green        = 1'b0;
      repeats_left = solid(s) ? 8'd1 : ENDLESS;
      fresh        = 1'b1;
      blink_level  = 1'b0;
    endfunction

    function void show(int unsigned s);
      case (kind_of[s])
        KIND_SOLID_GREEN: begin
          red   = 1'b0;
          green = 1'b1;
        end
        KIND_SOLID_RED: begin
          red   = 1'b1;
          green = 1'b0;
        end
        KIND_BLINK_GREEN: begin
          red         = 1'b0;
          blink_level = !blink_level;
          green       = blink_level;
        end
        default: begin
          green       = 1'b0;
          blink_level = !blink_level;
          red         = blink_level;
        end
      endcase
    endfunction

    function void tick();
      int unsigned w;
      if (powered_off || repeats_left == 0) return;
      w = top_slot();
      if (w == 0) return;
      if (fresh) begin
        fresh      = 1'b0;
        lit_count  = '0;
        dark_count = '0;
        in_lit     = 1'b1;
      end
      if (solid(w)) begin
        repeats_left = repeats_left - 8'd1;
        show(w);
        return;
      end
      if (in_lit) begin
        lit_count = lit_count + 5'd1;
        if (close_ticks[w] <= lit_count) begin
          in_lit = 1'b0;
          if (repeats_left < ENDLESS) repeats_left = repeats_left - 8'd1;
          lit_count = '0;
          show(w);
        end
      end else begin
        dark_count = dark_count + 5'd1;
        if (open_ticks[w] <= dark_count) begin
          in_lit     = 1'b1;
          dark_count = '0;
          show(w);
        end
      end
    endfunction

    // accepted input item: advance the prediction and queue the LED pair
    function void note_item(in_item_t it);
      int unsigned s;
      out_item_t   lv;
      s = it.status_slot;
      if (!it.test_hold) begin
        case (it.action)
          ACT_TICK: tick();
          ACT_RAISE: begin
            if (slot_valid(s)) begin
              active_mask[s] = 1'b1;
              load(s);
            end
          end
          ACT_DROP: begin
            if (slot_valid(s)) begin
              active_mask[s] = 1'b0;
              if (top_slot() != 0) load(top_slot());
            end
          end
          default: begin
            powered_off = 1'b1;
            red         = 1'b1;
            green       = 1'b0;
          end
        endcase
      end
      lv.red_on   = red;
      lv.green_on = green;
      levels_due.push_back(lv);
    endfunction

    task report(string what);
      $display("%0t ERROR: %s", $time, what);
      mismatches++;
    endtask

    task check_levels(out_item_t got);
      out_item_t want;
      if (levels_due.size() == 0) begin
        report($sformatf("result red=%0b green=%0b with no item pending",
                         got.red_on, got.green_on));
        return;
      end
      want = levels_due.pop_front();
      if (got.red_on !== want.red_on)
        report($sformatf("red_on %0b, predicted %0b", got.red_on, want.red_on));
      if (got.green_on !== want.green_on)
        report($sformatf("green_on %0b, predicted %0b", got.green_on, want.green_on));
      matched++;
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  led_level_scoreboard book;
  bit          quiet;
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;
  int unsigned stall_left;
  int unsigned cycles;
  int unsigned sent, useful;
  int unsigned n_tick, n_raise, n_drop, n_off, n_held;
  bit [11:0]   raised;

  priority_status_led_blinker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("priority_status_led_blinker_core: mismatch");
      $finish;
    end
  end

  // Result side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && out_gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 99) == 0) out_gaps_on = ($urandom_range(0, 2) != 0);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_levels(out_item);
  end

  function automatic in_item_t mk_item(logic [1:0] a, logic [SLOT_W-1:0] s, logic h);
    in_item_t it;
    it.action      = a;
    it.status_slot = s;
    it.test_hold   = h;
    return it;
  endfunction

  // Offer one item, with an optional idle burst first, and wait for accept
  task send_item(input in_item_t it);
    int unsigned gap;
    if (sent % 64 == 0) in_gaps_on = ($urandom_range(0, 2) != 0);
    if (!quiet && in_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_item(it);
    sent++;
    if (it.test_hold) n_held++;
    else begin
      case (it.action)
        ACT_TICK:      n_tick++;
        ACT_RAISE:     n_raise++;
        ACT_DROP:      n_drop++;
        default:       n_off++;
      endcase
      if (it.action == ACT_TICK || it.action == ACT_POWER_OFF ||
          book.slot_valid(it.status_slot)) useful++;
    end
  endtask

  task tick_run(input int unsigned n);
    repeat (n) send_item(mk_item(ACT_TICK, SLOT_W'($urandom_range(0, 15)), 1'b0));
  endtask

  task run_directed();
    tick_run(1);                              // tick with nothing active
    send_item(mk_item(ACT_RAISE, 4'd0, 1'b0));  // out of range slots
    send_item(mk_item(ACT_RAISE, 4'd12, 1'b0));
    send_item(mk_item(ACT_DROP, 4'd15, 1'b0));
    send_item(mk_item(ACT_RAISE, 4'd8, 1'b0));  // solid green, applied once
    tick_run(2);
    send_item(mk_item(ACT_RAISE, 4'd9, 1'b0));  // lower slot still blanks LEDs
    tick_run(1);
    send_item(mk_item(ACT_DROP, 4'd8, 1'b0));   // solid red takes over
    tick_run(1);
    send_item(mk_item(ACT_RAISE, 4'd1, 1'b0));  // blinking red
    tick_run(6);
    send_item(mk_item(ACT_RAISE, 4'd2, 1'b1));  // held, ignored
    send_item(mk_item(ACT_DROP, 4'd1, 1'b0));
    send_item(mk_item(ACT_DROP, 4'd9, 1'b0));   // none left, levels kept
    tick_run(1);
  endtask

  // Mostly raise-then-tick and drop-then-tick runs, with some noise
  task run_random(input int unsigned goal);
    int unsigned r, s;
    while (useful < goal) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(mk_item(2'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)), 1'b1));
      end else if (r < 10) begin
        s = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(12, 15);
        send_item(mk_item(r < 8 ? ACT_RAISE : ACT_DROP, SLOT_W'(s), 1'b0));
      end else if (r < 24) begin
        s = $urandom_range(1, 11);
        send_item(mk_item(ACT_RAISE, SLOT_W'(s), 1'b0));
        raised[s] = 1'b1;
        tick_run($urandom_range(1, 40));
      end else if (r < 38) begin
        s = $urandom_range(1, 11);
        if (raised != 0 && $urandom_range(0, 3) != 0)
          while (!raised[s]) s = $urandom_range(1, 11);
        send_item(mk_item(ACT_DROP, SLOT_W'(s), 1'b0));
        raised[s] = 1'b0;
        tick_run($urandom_range(0, 20));
      end else begin
        tick_run(1);
      end
    end
  endtask

  // Power off is sticky until reset, so it comes last
  task run_power_off();
    send_item(mk_item(ACT_POWER_OFF, 4'd15, 1'b0));
    tick_run(3);
    send_item(mk_item(ACT_RAISE, 4'd4, 1'b0));
    tick_run(2);
    send_item(mk_item(ACT_DROP, 4'd4, 1'b0));
    send_item(mk_item(ACT_RAISE, 4'd9, 1'b0));
    tick_run(1);
    send_item(mk_item(ACT_POWER_OFF, 4'd0, 1'b1));
    send_item(mk_item(ACT_POWER_OFF, 4'd3, 1'b0));
    send_item(mk_item(ACT_DROP, 4'd9, 1'b0));
  endtask

  initial begin
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_GOAL);
    quiet = 1'b1;
    run_random(useful + 40);
    run_power_off();
    in_valid <= 1'b0;
    while (book.levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.levels_due.size() != 0)
      book.report($sformatf("%0d results never arrived", book.levels_due.size()));
    $display("sent %0d items: %0d ticks, %0d raises, %0d drops, %0d power-offs, %0d held",
             sent, n_tick, n_raise, n_drop, n_off, n_held);
    $display("checked %0d LED results, %0d mismatches", book.matched, book.mismatches);
    if (book.mismatches == 0) begin
      $display("priority_status_led_blinker_core: match");
    end else begin
      $display("priority_status_led_blinker_core: mismatch");
    end
    $finish;
  end

endmodule
